FILE: hdl/ffia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffia_pkg
// Shared types and constants of the free index allocator.
// ----------------------------------------------------------------------------
package ffia_pkg;

  localparam int POOL_SIZE = 4096;
  localparam int IDX_W     = 12;   // width of a pool index
  localparam int CNT_W     = 13;   // holds 0 .. POOL_SIZE
  localparam int SLOT_W    = 16;   // width of the requested slot index

  typedef enum logic {
    OP_OBTAIN  = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_t;

endpackage

FILE: hdl/ffia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffia_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read during write returns the old contents
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fifo_free_index_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_free_index_allocator
// Hands out pool indices first-in first-out and takes them back on release.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ group: s_tuser is the operation (0 obtain,
//   1 release), s_tdata the slot index to release. Each request gives one
//   result on the m_ group: m_tuser the status, m_tdata the granted index
//   and the free count after the request.
//   Unissued indices go out in ascending order from a fresh counter, then
//   released indices in release order from a circular queue in RAM.
//   The result passes through the request stage and the result register;
//   one request per cycle is sustained while the receiver takes results.
//   Both RAM reads are issued at accept time, so the queue head address
//   is taken from the next-head logic of the request ahead, and a RAM
//   write made at the same edge is forwarded from a register.
//   Free flags are valid only below the fresh counter, so reset needs no
//   clearing pass; the block is ready at once after reset.
//   When the receiver stalls, the result register holds, the request stage
//   holds behind it, and s_tready falls once both are full.
// ----------------------------------------------------------------------------
module fifo_free_index_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] slot_index
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [11:0] granted_index, [24:12] free_count, zero fill
  output logic [1:0]  m_tuser    // [1:0] status
);
  import ffia_pkg::*;

  // request stage
  logic              s1_valid;
  op_t               s1_op;
  logic [SLOT_W-1:0] s1_idx;

  // allocator state
  logic [CNT_W-1:0] fresh;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // same-edge write forwarding
  logic             fwd_flag_valid;
  logic [IDX_W-1:0] fwd_flag_addr;
  logic             fwd_flag_data;
  logic             fwd_q_valid;
  logic [IDX_W-1:0] fwd_q_addr;
  logic [IDX_W-1:0] fwd_q_data;

  logic             flag_rd;
  logic [IDX_W-1:0] q_rd;

  logic             accept;
  logic             commit;
  logic             flag_cur;
  logic [IDX_W-1:0] q_cur;
  logic             is_free;

  status_t          res_status;
  logic [IDX_W-1:0] res_grant;
  logic [CNT_W-1:0] res_free;
  logic             take_fresh;
  logic             pop;
  logic             push;
  logic             flag_we;
  logic [IDX_W-1:0] flag_waddr;
  logic             flag_wdata;
  logic [CNT_W-1:0] fresh_item;
  logic [CNT_W-1:0] count_item;

  logic [CNT_W-1:0] fresh_next;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;
  logic [CNT_W-1:0] count_next;

  assign commit   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!s1_valid || commit);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    flag_cur = (fwd_flag_valid && fwd_flag_addr == s1_idx[IDX_W-1:0]) ? fwd_flag_data
                                                                         : flag_rd;
    q_cur    = (fwd_q_valid && fwd_q_addr == head) ? fwd_q_data : q_rd;
    // never-issued indices are free whatever the flag RAM holds
    is_free  = (CNT_W'(s1_idx[IDX_W-1:0]) >= fresh) || flag_cur;

    res_status = ST_OK;
    res_grant  = '0;
    take_fresh = 1'b0;
    pop        = 1'b0;
    push       = 1'b0;
    flag_we    = 1'b0;
    flag_waddr = s1_idx[IDX_W-1:0];
    flag_wdata = 1'b1;

    unique case (s1_op)
      OP_OBTAIN: begin
        priority if (fresh < CNT_W'(POOL_SIZE)) begin
          take_fresh = 1'b1;
          res_grant  = fresh[IDX_W-1:0];
          flag_we    = 1'b1;
          flag_waddr = fresh[IDX_W-1:0];
          flag_wdata = 1'b0;
        end else if (count != '0) begin
          pop        = 1'b1;
          res_grant  = q_cur;
          flag_we    = 1'b1;
          flag_waddr = q_cur;
          flag_wdata = 1'b0;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      OP_RELEASE: begin
        priority if (s1_idx >= SLOT_W'(POOL_SIZE)) begin
          res_status = ST_RANGE;
        end else if (is_free || count >= CNT_W'(POOL_SIZE)) begin
          res_status = ST_FREE;
        end else begin
          push    = 1'b1;
          flag_we = 1'b1;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase

    fresh_item = take_fresh ? fresh + CNT_W'(1) : fresh;
    count_item = count + CNT_W'(push) - CNT_W'(pop);
    res_free   = CNT_W'(POOL_SIZE) - fresh_item + count_item;

    fresh_next = commit ? fresh_item : fresh;
    count_next = commit ? count_item : count;
    head_next  = head;
    if (commit && pop) begin
      head_next = (head == IDX_W'(POOL_SIZE - 1)) ? '0 : head + IDX_W'(1);
    end
    tail_next  = tail;
    if (commit && push) begin
      tail_next = (tail == IDX_W'(POOL_SIZE - 1)) ? '0 : tail + IDX_W'(1);
    end
  end

  ffia_ram #(
    .WIDTH (1),
    .DEPTH (POOL_SIZE)
  ) u_flag_ram (
    .clk   (clk),
    .we    (commit && flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (accept),
    .raddr (s_tdata[IDX_W-1:0]),
    .rdata (flag_rd)
  );

  ffia_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_SIZE)
  ) u_queue_ram (
    .clk   (clk),
    .we    (commit && push),
    .waddr (tail),
    .wdata (s1_idx[IDX_W-1:0]),
    .re    (accept),
    .raddr (head_next),
    .rdata (q_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      fresh          <= '0;
      head           <= '0;
      tail           <= '0;
      count          <= '0;
      fwd_flag_valid <= 1'b0;
      fwd_q_valid    <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      fresh <= fresh_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;

      if (accept) begin
        s1_valid       <= 1'b1;
        // only a write landing at the read edge is missing from the RAM data
        fwd_flag_valid <= commit && flag_we;
        fwd_q_valid    <= commit && push;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end

      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op         <= op_t'(s_tuser);
      s1_idx        <= s_tdata;
      fwd_flag_addr <= flag_waddr;
      fwd_flag_data <= flag_wdata;
      fwd_q_addr    <= tail;
      fwd_q_data    <= s1_idx[IDX_W-1:0];
    end
    if (commit) begin
      m_tuser <= res_status;
      m_tdata <= {7'd0, res_free, res_grant};
    end
  end

endmodule

FILE: hdl/ffia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffia_checker
// Port-level checks on the result channel of the free index allocator.
// ----------------------------------------------------------------------------
module ffia_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import ffia_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // only a successful obtain carries an index
  a_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[11:0] == 12'd0)
    else $error("granted index on failed request");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[24:12] <= 13'(POOL_SIZE))
    else $error("free count above pool size");

  // pool empty means nothing free
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[24:12] == 13'd0)
    else $error("empty status with free indices");

endmodule

bind fifo_free_index_allocator ffia_checker u_ffia_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: bench/fifo_free_index_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_free_index_allocator_tb
// Self-checking bench for the first-in first-out free index allocator.
// Obtain and release requests go in on the slave stream. A ledger of the
// pool tracks the fresh counter, the recycle order and the free flags, and
// predicts every reply on the master stream. The run starts with a few
// directed corner requests, then mixes obtains, releases of held indices
// and bad releases. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module fifo_free_index_allocator_tb;
  import ffia_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] grant;
    logic [CNT_W-1:0] free_cnt;
  } alloc_reply_t;

  class slot_pool_ledger;
    int unsigned      fresh_next;
    logic [IDX_W-1:0] recycled[$];     // released indices, oldest first
    bit               free_flag[POOL_SIZE];
    int               held[$];         // indices handed out and not yet back
    alloc_reply_t     pending[$];
    int unsigned      errors;

    function new();
      fresh_next = 0;
      errors     = 0;
      foreach (free_flag[i]) free_flag[i] = 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    function void drop_held(int idx);
      for (int k = 0; k < held.size(); k++) begin
        if (held[k] == idx) begin
          held[k] = held[held.size()-1];
          void'(held.pop_back());
          return;
        end
      end
    endfunction

    function void log_request(op_t op, logic [SLOT_W-1:0] slot);
      alloc_reply_t r;
      r.status = ST_OK;
      r.grant  = '0;
      if (op == OP_OBTAIN) begin
        if (fresh_next < POOL_SIZE) begin
          r.grant = fresh_next[IDX_W-1:0];
          free_flag[fresh_next] = 1'b0;
          held.insert(held.size(), int'(fresh_next));
          fresh_next++;
        end else if (recycled.size() > 0) begin
          r.grant = recycled[0];
          recycled.delete(0);
          free_flag[r.grant] = 1'b0;
          held.insert(held.size(), int'(r.grant));
        end else begin
          r.status = ST_EMPTY;
        end
      end else if (slot >= POOL_SIZE) begin
        r.status = ST_RANGE;
      end else if (free_flag[slot] || recycled.size() >= POOL_SIZE) begin
        r.status = ST_FREE;
      end else begin
        free_flag[slot] = 1'b1;
        recycled.insert(recycled.size(), slot[IDX_W-1:0]);
        drop_held(int'(slot));
      end
      r.free_cnt = CNT_W'(POOL_SIZE - fresh_next + recycled.size());
      pending.insert(pending.size(), r);
    endfunction

    task check_reply(logic [1:0] st, logic [31:0] data);
      alloc_reply_t r;
      if (pending.size() == 0) begin
        report($sformatf("reply with no request waiting: status %0d data %h", st, data));
        return;
      end
      r = pending[0];
      pending.delete(0);
      if (st !== r.status)
        report($sformatf("status %0d, want %0d", st, r.status));
      if (data[IDX_W-1:0] !== r.grant)
        report($sformatf("granted index %0d, want %0d", data[IDX_W-1:0], r.grant));
      if (data[IDX_W+CNT_W-1:IDX_W] !== r.free_cnt)
        report($sformatf("free count %0d, want %0d", data[IDX_W+CNT_W-1:IDX_W],
                         r.free_cnt));
      if (data[31:IDX_W+CNT_W] !== '0)
        report($sformatf("fill bits of reply not zero: %h", data));
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  slot_pool_ledger ledger = new();
  int unsigned     cycles     = 0;
  int              stall_left = 0;
  bit              calm       = 1'b0;   // no idling on either side while set

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fifo_free_index_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check_reply(m_tuser, m_tdata);
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // valid is only dropped when a gap follows, never between back-to-back requests
  task send_request(op_t op, logic [15:0] slot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= slot;
    do @(posedge clk); while (s_tready !== 1'b1);
    ledger.log_request(op, slot);
  endtask

  task obtain_index();
    send_request(OP_OBTAIN, 16'($urandom_range(0, 65535)));
  endtask

  task random_request(int obtain_pct);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < obtain_pct) begin
      obtain_index();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 78 && ledger.held.size() > 0) begin
        k = $urandom_range(0, ledger.held.size() - 1);
        send_request(OP_RELEASE, 16'(ledger.held[k]));
      end else if (r < 84 && ledger.recycled.size() > 0) begin
        k = $urandom_range(0, ledger.recycled.size() - 1);
        send_request(OP_RELEASE, 16'(ledger.recycled[k]));
      end else if (r < 90) begin
        send_request(OP_RELEASE, 16'($urandom_range(0, POOL_SIZE - 1)));
      end else if (r < 95) begin
        send_request(OP_RELEASE, 16'($urandom_range(POOL_SIZE, 65535)));
      end else begin
        send_request(OP_RELEASE, 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    int n;
    int pct;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing issued yet, so every in-range release is already free
    send_request(OP_RELEASE, 16'd0);
    send_request(OP_RELEASE, 16'(POOL_SIZE));
    send_request(OP_RELEASE, 16'hFFFF);
    send_request(OP_RELEASE, 16'(POOL_SIZE - 1));
    obtain_index();
    obtain_index();
    obtain_index();
    send_request(OP_RELEASE, 16'd1);
    send_request(OP_RELEASE, 16'd1);
    obtain_index();                        // fresh counter still takes priority
    send_request(OP_RELEASE, 16'd0);
    send_request(OP_RELEASE, 16'd2);
    send_request(OP_RELEASE, 16'd3);
    send_request(OP_RELEASE, 16'hAAAA);
    send_request(OP_RELEASE, 16'h5555);
    send_request(OP_RELEASE, 16'h0AAA);

    pct = 50;
    for (n = 0; n < 1834; n++) begin
      if (n % 100 == 0) begin
        pct  = $urandom_range(35, 65);
        calm = ($urandom_range(0, 3) == 0);
      end
      random_request(pct);
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ffia_pkg.sv
hdl/ffia_ram.sv
hdl/fifo_free_index_allocator.sv
hdl/ffia_checker.sv
bench/fifo_free_index_allocator_tb.sv
